[design/servo_eased_slew_step_unit_defines.svh]
// assertion macros shared by the servo eased slew step design
`ifndef SERVO_EASED_SLEW_STEP_UNIT_DEFINES_SVH
`define SERVO_EASED_SLEW_STEP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SESS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define SESS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/sess_pkg.sv]
// shared types and constants of the servo eased slew step unit
`default_nettype none

package sess_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int SPAN_W  = 10;
    localparam int ANGLE_W = 8;
    localparam int PCT_W   = 7;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 2;

    localparam logic [CMD_W-1:0] CMD_HEAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BODY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ARM  = 2'd2;

    localparam logic [IDX_W-1:0] REG_HEAD_SPAN = 2'd0;
    localparam logic [IDX_W-1:0] REG_BODY_SPAN = 2'd1;
    localparam logic [IDX_W-1:0] REG_ARM_SPAN  = 2'd2;

    localparam logic [SPAN_W-1:0] HEAD_SPAN_RESET = 10'd200;
    localparam logic [SPAN_W-1:0] BODY_SPAN_RESET = 10'd260;
    localparam logic [SPAN_W-1:0] ARM_SPAN_RESET  = 10'd320;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // per-item sideband that rides along the pipeline
    typedef struct packed {
        logic               arm;
        logic [ANGLE_W-1:0] cur;
        logic [ANGLE_W-1:0] mag;
        logic               up;
        logic               same;
        logic               sat;
        logic [PCT_W-1:0]   pct;
    } item_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } div_ctl_t;

endpackage

`default_nettype wire

[design/sess_if.sv]
// handshake channels for items and results
`default_nettype none

interface sess_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] current_angle;
    logic [7:0] target_angle;
    logic [15:0] elapsed_ms;
    logic [6:0] random_pct;

    modport source (output valid, command, current_angle, target_angle, elapsed_ms,
                    random_pct, input ready);
    modport sink (input valid, command, current_angle, target_angle, elapsed_ms,
                  random_pct, output ready);
endinterface

interface sess_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] next_angle;

    modport source (output valid, next_angle, input ready);
    modport sink (input valid, next_angle, output ready);
endinterface

`default_nettype wire

[design/sess_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none

module sess_div #(
    parameter int FRAC_BITS = sess_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sess_pkg::div_ctl_t          ctl,
    input  wire logic [sess_pkg::SPAN_W-1:0] rem_init,
    input  wire logic [sess_pkg::SPAN_W-1:0] divisor,
    input  wire sess_pkg::item_t             side_in,
    output logic                             valid,
    output logic [FRAC_BITS-1:0]             quotient,
    output sess_pkg::item_t                  side_out
);

    localparam int SW = sess_pkg::SPAN_W;

    logic [FRAC_BITS:0]   valid_reg;
    logic [SW-1:0]        rem_reg  [FRAC_BITS+1];
    logic [SW-1:0]        dvs_reg  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] quo_reg  [FRAC_BITS+1];
    sess_pkg::item_t      side_reg [FRAC_BITS+1];

    logic [SW-1:0]        rem_next [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] quo_next [FRAC_BITS+1];

    assign rem_next[0] = rem_init;
    assign quo_next[0] = '0;

    // remainder stays below the divisor, so the doubled trial fits in one extra bit
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [SW:0] trial;
        logic [SW:0] diff;
        logic        ge;
        assign trial = {rem_reg[k-1], 1'b0};
        assign diff  = trial - {1'b0, dvs_reg[k-1]};
        assign ge    = trial >= {1'b0, dvs_reg[k-1]};
        assign rem_next[k] = ge ? diff[SW-1:0] : trial[SW-1:0];
        assign quo_next[k] = {quo_reg[k-1][FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= {valid_reg[FRAC_BITS-1:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            dvs_reg[0]  <= divisor;
            side_reg[0] <= side_in;
            for (int k = 0; k <= FRAC_BITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k <= FRAC_BITS; k++)
            begin
                dvs_reg[k]  <= dvs_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign valid    = valid_reg[FRAC_BITS];
    assign quotient = quo_reg[FRAC_BITS];
    assign side_out = side_reg[FRAC_BITS];

endmodule

`default_nettype wire

[design/servo_eased_slew_step_unit.sv]
// an item passes through the divider stages, then stages a to e and the output register
// throughput: one item per cycle unless the result side stalls; the t = dt/span divider
// resolves one bit per stage and the easing and step multipliers each own a stage, so every
// stage is busy each cycle; a stall at the result side holds the whole pipeline in place
// reset empties the pipeline and sets the spans to 200, 260 and 320 ms
`default_nettype none
`include "servo_eased_slew_step_unit_defines.svh"

module servo_eased_slew_step_unit #(
    parameter int FRAC_BITS = sess_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [sess_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [sess_pkg::SPAN_W-1:0] cfg_data,
    sess_item_if.sink                        item,
    sess_result_if.source                    result
);

    localparam int F  = FRAC_BITS;
    localparam int SW = sess_pkg::SPAN_W;
    localparam int AW = sess_pkg::ANGLE_W;
    localparam int MU_W   = F + 1 + AW;
    localparam int PROD_W = MU_W + F + 1;

    localparam logic [63:0] C52_64 = ((64'd52 << F) + 64'd50) / 64'd100;
    localparam logic [63:0] C02_64 = ((64'd2 << F) + 64'd50) / 64'd100;
    localparam logic [63:0] C04_64 = ((64'd4 << F) + 64'd50) / 64'd100;
    localparam logic [F-1:0] C52 = C52_64[F-1:0];
    localparam logic [F:0]   U_MIN_ARM  = C02_64[F:0];
    localparam logic [F:0]   U_MIN_BODY = C04_64[F:0];
    localparam logic [F:0]   QONE = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0] THREE_Q = (F+2)'(3) << F;
    localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (2*F - 1);

    // ---------------- configuration ----------------
    logic [SW-1:0] head_span_reg, body_span_reg, arm_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_span_reg <= sess_pkg::HEAD_SPAN_RESET;
            body_span_reg <= sess_pkg::BODY_SPAN_RESET;
            arm_span_reg  <= sess_pkg::ARM_SPAN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sess_pkg::REG_HEAD_SPAN: head_span_reg <= cfg_data;
                sess_pkg::REG_BODY_SPAN: body_span_reg <= cfg_data;
                sess_pkg::REG_ARM_SPAN:  arm_span_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- variation tables ----------------
    logic [F:0] vary_body_tab [101];
    logic [F:0] vary_arm_tab  [101];

    for (genvar g = 0; g <= 100; g++)
    begin : g_vary
        localparam logic [63:0] VB = ((64'(9000 + 22 * g) << F) + 64'd5000) / 64'd10000;
        localparam logic [63:0] VA = ((64'(8800 + 20 * g) << F) + 64'd5000) / 64'd10000;
        assign vary_body_tab[g] = VB[F:0];
        assign vary_arm_tab[g]  = VA[F:0];
    end

    // ---------------- global advance ----------------
    logic out_valid_reg;
    logic adv;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    // ---------------- input decode ----------------
    logic [SW-1:0]   span_sel, span_eff;
    logic            sat;
    logic [SW-1:0]   rem_init;
    sess_pkg::item_t side_in;

    always_comb
    begin
        case (item.command)
            sess_pkg::CMD_HEAD: span_sel = head_span_reg;
            sess_pkg::CMD_ARM:  span_sel = arm_span_reg;
            default:            span_sel = body_span_reg;
        endcase
        span_eff = (span_sel == '0) ? SW'(1) : span_sel;
        sat      = item.elapsed_ms >= {{(16-SW){1'b0}}, span_eff};
        rem_init = sat ? '0 : item.elapsed_ms[SW-1:0];

        side_in.arm  = item.command == sess_pkg::CMD_ARM;
        side_in.cur  = item.current_angle;
        side_in.up   = item.target_angle > item.current_angle;
        side_in.mag  = side_in.up ? item.target_angle - item.current_angle
                                  : item.current_angle - item.target_angle;
        side_in.same = item.target_angle == item.current_angle;
        side_in.sat  = sat;
        side_in.pct  = (item.random_pct > sess_pkg::PCT_MAX) ? sess_pkg::PCT_MAX
                                                            : item.random_pct;
    end

    // ---------------- t = dt / span ----------------
    sess_pkg::div_ctl_t div_ctl;
    logic            div_valid;
    logic [F-1:0]    div_t;
    sess_pkg::item_t div_item;

    assign div_ctl.advance = adv;
    assign div_ctl.valid   = item.valid;

    sess_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (rem_init),
        .divisor  (span_eff),
        .side_in  (side_in),
        .valid    (div_valid),
        .quotient (div_t),
        .side_out (div_item)
    );

    // ---------------- easing and step pipeline ----------------
    logic            a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    sess_pkg::item_t a_item_reg, b_item_reg, c_item_reg, d_item_reg, e_item_reg;
    logic [F-1:0]    a_t_reg, a_t2_reg;
    logic [F:0]      b_u0_reg;
    logic [F:0]      c_u_reg, c_vary_reg;
    logic [MU_W-1:0] d_mu_reg;
    logic [F:0]      d_vary_reg;
    logic [PROD_W-1:0] e_prod_reg;
    logic [AW-1:0]   out_angle_reg;

    logic [2*F-1:0]    a_t2_next_full;
    logic [F+1:0]      b_lin;
    logic [2*F+1:0]    b_prod;
    logic [F:0]        b_u0_next;
    logic [2*F:0]      c_arm_prod;
    logic [F:0]        c_u_next, c_vary_next;
    logic [MU_W-1:0]   d_mu_next;
    logic [PROD_W-1:0] e_prod_next;
    logic [PROD_W:0]   f_sum;
    logic [PROD_W-2*F:0] f_step_raw;
    logic [AW-1:0]     f_step;
    logic [AW-1:0]     out_angle_next;

    always_comb
    begin
        a_t2_next_full = div_t * div_t;

        b_lin     = THREE_Q - {1'b0, a_t_reg, 1'b0};
        b_prod    = a_t2_reg * b_lin;
        // smoothstep never exceeds one, so the top product bit is always clear
        b_u0_next = a_item_reg.sat ? QONE : b_prod[2*F:F];

        c_arm_prod = b_u0_reg * C52;
        if (b_item_reg.arm)
        begin
            c_u_next    = (c_arm_prod[2*F:F] < U_MIN_ARM) ? U_MIN_ARM : c_arm_prod[2*F:F];
            c_vary_next = vary_arm_tab[b_item_reg.pct];
        end
        else
        begin
            c_u_next    = (b_u0_reg < U_MIN_BODY) ? U_MIN_BODY : b_u0_reg;
            c_vary_next = vary_body_tab[b_item_reg.pct];
        end

        d_mu_next   = c_item_reg.mag * c_u_reg;
        e_prod_next = d_mu_reg * d_vary_reg;

        // round half up on the magnitude, then force a step of at least one and at most the magnitude
        f_sum      = {1'b0, e_prod_reg} + HALF;
        f_step_raw = f_sum[PROD_W:2*F];
        if (f_step_raw == '0)
        begin
            f_step = AW'(1);
        end
        else if (f_step_raw > {{(PROD_W-2*F+1-AW){1'b0}}, e_item_reg.mag})
        begin
            f_step = e_item_reg.mag;
        end
        else
        begin
            f_step = f_step_raw[AW-1:0];
        end

        if (e_item_reg.same)
        begin
            out_angle_next = e_item_reg.cur;
        end
        else if (e_item_reg.up)
        begin
            out_angle_next = e_item_reg.cur + f_step;
        end
        else
        begin
            out_angle_next = e_item_reg.cur - f_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= div_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg    <= div_item;
            a_t_reg       <= div_t;
            a_t2_reg      <= a_t2_next_full[2*F-1:F];
            b_item_reg    <= a_item_reg;
            b_u0_reg      <= b_u0_next;
            c_item_reg    <= b_item_reg;
            c_u_reg       <= c_u_next;
            c_vary_reg    <= c_vary_next;
            d_item_reg    <= c_item_reg;
            d_mu_reg      <= d_mu_next;
            d_vary_reg    <= c_vary_reg;
            e_item_reg    <= d_item_reg;
            e_prod_reg    <= e_prod_next;
            out_angle_reg <= out_angle_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.next_angle = out_angle_reg;

    // ---------------- checks ----------------
    `SESS_ASSERT_NOW(a_empty_out_takes_item, !result.valid, item.ready)
    `SESS_ASSERT_NEXT(a_last_stage_reaches_out, adv && e_valid_reg, result.valid)
    `SESS_ASSERT_NOW(a_ease_in_range, c_valid_reg,
                     (c_u_reg <= QONE) && (c_u_reg >= U_MIN_ARM))

endmodule

`default_nettype wire

[tb/sv/servo_eased_slew_step_unit_tb.sv]
// self-checking testbench of the servo eased slew step unit: table rows, then random items
`timescale 1ns / 100ps

module servo_eased_slew_step_unit_tb;

    import sess_pkg::*;

    localparam int FB = FRAC_BITS_DEFAULT;
    localparam logic [63:0] Q_ONE = 64'd1 << FB;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 2 * (FB + 7);
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int N_ROWS = 20;

    // command and register index that the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ANGLE_W-1:0] current_angle;
        logic [ANGLE_W-1:0] target_angle;
        logic [15:0]        elapsed_ms;
        logic [PCT_W-1:0]   random_pct;
    } servo_item_t;

    typedef struct packed {
        servo_item_t        stim;
        logic               known;
        logic [ANGLE_W-1:0] angle;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [IDX_W-1:0] cfg_index;
    logic [SPAN_W-1:0] cfg_data;

    sess_item_if item_ch ();
    sess_result_if result_ch ();

    servo_eased_slew_step_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // span copies that the predictor works from
    logic [SPAN_W-1:0] head_span;
    logic [SPAN_W-1:0] body_span;
    logic [SPAN_W-1:0] arm_span;

    logic [ANGLE_W-1:0] expected_angles [$];
    table_row_t directed_rows [N_ROWS];

    int error_count;
    int items_sent;
    int results_checked;
    int settings_used;
    int cycle_count;
    int hold_left;
    bit quiet_run;
    bit hold_req;
    bit hold_taken;

    always #10 clk = ~clk;

    function automatic logic [63:0] q_ratio(input logic [63:0] num, input logic [63:0] den);
        return ((num << FB) + (den / 2)) / den;
    endfunction

    function automatic logic [SPAN_W-1:0] span_for(input logic [CMD_W-1:0] cmd);
        case (cmd)
            CMD_HEAD: return head_span;
            CMD_ARM:  return arm_span;
            default:  return body_span;
        endcase
    endfunction

    // smoothstep of dt/span in Q1.FB, saturating at one
    function automatic logic [63:0] ease_fraction(input logic [15:0] dt,
                                                  input logic [SPAN_W-1:0] span);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lin;
        s = (span == '0) ? 64'd1 : 64'(span);
        if (64'(dt) >= s)
            return Q_ONE;
        t = (64'(dt) << FB) / s;
        t2 = (t * t) >> FB;
        lin = 3 * Q_ONE - 2 * t;
        return (t2 * lin) >> FB;
    endfunction

    function automatic logic [ANGLE_W-1:0] eased_next_angle(input servo_item_t it);
        logic [63:0] mag;
        logic [63:0] pct;
        logic [63:0] u;
        logic [63:0] vary;
        logic [63:0] prod;
        logic [63:0] step;
        logic up;
        if (it.current_angle == it.target_angle)
            return it.current_angle;
        up = it.target_angle > it.current_angle;
        mag = up ? 64'(it.target_angle) - 64'(it.current_angle)
                 : 64'(it.current_angle) - 64'(it.target_angle);
        pct = (it.random_pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(it.random_pct);
        if (it.command == CMD_ARM) begin
            u = (ease_fraction(it.elapsed_ms, arm_span) * q_ratio(52, 100)) >> FB;
            if (u < q_ratio(2, 100))
                u = q_ratio(2, 100);
            vary = q_ratio(8800 + 20 * pct, 10000);
        end
        else begin
            u = ease_fraction(it.elapsed_ms, span_for(it.command));
            if (u < q_ratio(4, 100))
                u = q_ratio(4, 100);
            vary = q_ratio(9000 + 22 * pct, 10000);
        end
        if (u > Q_ONE)
            u = Q_ONE;
        prod = mag * u * vary;
        step = (prod + (64'd1 << (2 * FB - 1))) >> (2 * FB);
        if (step == 0)
            step = 1;
        if (step > mag)
            step = mag;
        return up ? it.current_angle + step[ANGLE_W-1:0]
                  : it.current_angle - step[ANGLE_W-1:0];
    endfunction

    function automatic servo_item_t make_random_item();
        servo_item_t it;
        int span;
        int pick;
        it.command = CMD_W'($urandom_range(0, 3));
        span = int'(span_for(it.command));
        if (span == 0)
            span = 1;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.elapsed_ms = 16'($urandom_range(0, span * 5 / 4 + 2));
        else if (pick < 85)
            it.elapsed_ms = 16'($urandom_range(0, 65535));
        else
            it.elapsed_ms = 16'((span > 2 ? span - 2 : 0) + $urandom_range(0, 3));
        it.current_angle = ($urandom_range(0, 99) < 85) ? ANGLE_W'($urandom_range(0, 180))
                                                        : ANGLE_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.target_angle = it.current_angle;
        else if (pick < 20)
            it.target_angle = $urandom_range(0, 1) ? it.current_angle + 8'd1
                                                   : it.current_angle - 8'd1;
        else if (pick < 85)
            it.target_angle = ANGLE_W'($urandom_range(0, 180));
        else
            it.target_angle = ANGLE_W'($urandom_range(0, 255));
        it.random_pct = ($urandom_range(0, 99) < 85) ? PCT_W'($urandom_range(0, 100))
                                                     : PCT_W'($urandom_range(0, 127));
        return it;
    endfunction

    task automatic drive_item(input servo_item_t it, input logic known,
                              input logic [ANGLE_W-1:0] typed_angle);
        while (!quiet_run && $urandom_range(0, 99) < 12) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= it.command;
        item_ch.current_angle <= it.current_angle;
        item_ch.target_angle <= it.target_angle;
        item_ch.elapsed_ms <= it.elapsed_ms;
        item_ch.random_pct <= it.random_pct;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_angles.push_back(known ? typed_angle : eased_next_angle(it));
        items_sent++;
    endtask

    task automatic random_burst(input int count);
        repeat (count)
            drive_item(make_random_item(), 1'b0, '0);
    endtask

    // stop offering and wait for the pipeline to hand back everything
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_angles.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_spans(input logic [SPAN_W-1:0] h, input logic [SPAN_W-1:0] b,
                             input logic [SPAN_W-1:0] a, input bit stray);
        cfg_write <= 1'b1;
        cfg_index <= REG_HEAD_SPAN;
        cfg_data <= h;
        @(posedge clk);
        head_span = h;
        cfg_index <= REG_BODY_SPAN;
        cfg_data <= b;
        @(posedge clk);
        body_span = b;
        cfg_index <= REG_ARM_SPAN;
        cfg_data <= a;
        @(posedge clk);
        arm_span = a;
        // an unused index must leave every span alone
        if (stray) begin
            cfg_index <= REG_NONE;
            cfg_data <= SPAN_W'($urandom_range(0, 1023));
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken) begin
            result_ch.ready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_taken <= 1'b1;
        end
        else begin
            result_ch.ready <= quiet_run || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge clk) begin : check_results
        logic [ANGLE_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_angles.size() == 0) begin
                $error("next_angle transfer with nothing expected: actual %0d",
                       result_ch.next_angle);
                error_count++;
            end
            else begin
                want = expected_angles.pop_front();
                results_checked++;
                if (result_ch.next_angle !== want) begin
                    $error("next_angle mismatch: expected %0d, actual %0d",
                           want, result_ch.next_angle);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_angles.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int idx;
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_HEAD_SPAN;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_HEAD;
        item_ch.current_angle = '0;
        item_ch.target_angle = '0;
        item_ch.elapsed_ms = '0;
        item_ch.random_pct = '0;
        result_ch.ready = 1'b0;
        head_span = HEAD_SPAN_RESET;
        body_span = BODY_SPAN_RESET;
        arm_span = ARM_SPAN_RESET;
        error_count = 0;
        items_sent = 0;
        results_checked = 0;
        settings_used = 1;
        cycle_count = 0;
        hold_left = 0;
        quiet_run = 1'b0;
        hold_req = 1'b0;
        hold_taken = 1'b0;

        // spans at reset: head 200, body 260, arm 320
        directed_rows = '{
            '{'{CMD_HEAD,  8'd90,  8'd90,  16'd0,     7'd0},   1'b1, 8'd90},
            '{'{CMD_BODY,  8'd0,   8'd0,   16'd65535, 7'd127}, 1'b1, 8'd0},
            '{'{CMD_ARM,   8'd255, 8'd255, 16'd1000,  7'd50},  1'b1, 8'd255},
            '{'{CMD_HEAD,  8'd0,   8'd180, 16'd65535, 7'd100}, 1'b1, 8'd180},
            '{'{CMD_BODY,  8'd180, 8'd0,   16'd260,   7'd127}, 1'b1, 8'd0},
            '{'{CMD_HEAD,  8'd100, 8'd101, 16'd0,     7'd0},   1'b1, 8'd101},
            '{'{CMD_ARM,   8'd101, 8'd100, 16'd0,     7'd0},   1'b1, 8'd100},
            '{'{CMD_ARM,   8'd0,   8'd180, 16'd65535, 7'd100}, 1'b0, 8'd0},
            '{'{CMD_HEAD,  8'd0,   8'd180, 16'd0,     7'd0},   1'b0, 8'd0},
            '{'{CMD_ARM,   8'd180, 8'd0,   16'd0,     7'd0},   1'b0, 8'd0},
            '{'{CMD_SPARE, 8'd10,  8'd170, 16'd130,   7'd50},  1'b0, 8'd0},
            '{'{CMD_HEAD,  8'd0,   8'd255, 16'd199,   7'd100}, 1'b0, 8'd0},
            '{'{CMD_BODY,  8'd255, 8'd0,   16'd65535, 7'd0},   1'b0, 8'd0},
            '{'{CMD_ARM,   8'd20,  8'd160, 16'd160,   7'd73},  1'b0, 8'd0},
            '{'{CMD_HEAD,  8'd45,  8'd135, 16'd100,   7'd100}, 1'b0, 8'd0},
            '{'{CMD_BODY,  8'd200, 8'd3,   16'd1,     7'd1},   1'b0, 8'd0},
            '{'{CMD_ARM,   8'd0,   8'd255, 16'd319,   7'd127}, 1'b0, 8'd0},
            '{'{CMD_HEAD,  8'd250, 8'd5,   16'd65535, 7'd100}, 1'b1, 8'd5},
            '{'{CMD_ARM,   8'd255, 8'd0,   16'd65535, 7'd100}, 1'b0, 8'd0},
            '{'{CMD_SPARE, 8'd180, 8'd179, 16'd65535, 7'd100}, 1'b1, 8'd179}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < N_ROWS; idx++)
            drive_item(directed_rows[idx].stim, directed_rows[idx].known,
                       directed_rows[idx].angle);
        random_burst(50);
        settle();

        set_spans(10'd1, 10'd1, 10'd1, 1'b0);
        random_burst(80);
        settle();

        // long result stall while items keep coming, so the input backs up
        set_spans(10'd1023, 10'd1023, 10'd1023, 1'b0);
        random_burst(40);
        hold_req = 1'b1;
        random_burst(40);
        settle();

        // zero spans behave as one millisecond
        set_spans(10'd0, 10'd0, 10'd0, 1'b1);
        random_burst(60);
        settle();

        for (phase = 0; phase < 5; phase++) begin
            set_spans(SPAN_W'($urandom_range(1, 1023)), SPAN_W'($urandom_range(1, 1023)),
                      SPAN_W'($urandom_range(1, 1023)), 1'b0);
            quiet_run = (phase == 1);
            random_burst(48);
            // sender pauses mid-phase until the pipeline is empty
            if (phase == 2)
                settle();
            random_burst(48);
            settle();
        end
        quiet_run = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_angles.size() != 0) begin
            $error("next_angle: %0d results never arrived", expected_angles.size());
            error_count++;
        end

        $display("%0d items transferred (%0d table rows) under %0d span settings",
                 items_sent, N_ROWS, settings_used);
        $display("%0d next_angle results compared, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
